### rtl/rti_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/triangle unit.
// Used by rtl/ray_triangle_intersect.sv; depends on nothing else.
package rti_pkg;

  // Number format: signed fixed point, FB fraction bits in CW bits
  localparam int CW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * CW;
  localparam int NW = 18;               // unit normal component width

  // Normalization datapath widths
  localparam int NS_W   = 24;           // scaled magnitude, top bit at NS_W-1
  localparam int MSB_W  = $clog2(CW);
  localparam int SQ_W   = 2 * NS_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = NS_W + 1;
  localparam int NQ_W   = FB + 1;

  // Config register map
  localparam int          ADDR_W      = 2;
  localparam int          THR_W       = 17;
  localparam logic [ADDR_W-1:0] REG_DET_THR = 2'd0;
  localparam logic [THR_W-1:0]  THR_RESET   = 17'd1;

  // Item codes
  localparam logic       MODE_LOAD = 1'b0;
  localparam logic       MODE_RAY  = 1'b1;
  localparam logic [1:0] VSEL_A    = 2'd0;
  localparam logic [1:0] VSEL_B    = 2'd1;
  localparam logic [1:0] VSEL_C    = 2'd2;

  // Pipeline stage map
  localparam int S_IN       = 0;   // edges, origin offset
  localparam int S_MUL1     = 1;   // cross product terms
  localparam int S_CRS      = 2;   // H, Q, N
  localparam int S_MUL2     = 3;   // dot product terms, |N|
  localparam int S_DOT      = 4;   // det, nu, nv, nt, leading byte of |N|
  localparam int S_HIT      = 5;   // hit test, divider setup, MSB of |N|
  localparam int TDIV_FIRST = 6;   // t quotient, one bit per stage
  localparam int TDIV_LAST  = TDIV_FIRST + CW - 1;
  localparam int S_TSAT     = TDIV_LAST + 1;
  localparam int S_PMUL     = S_TSAT + 1;
  localparam int S_PADD     = S_PMUL + 1;
  localparam int S_NSHF     = 6;   // scale |N|
  localparam int S_NSQ      = 7;
  localparam int S_NSUM     = 8;
  localparam int SQ_FIRST   = 9;   // square root, one bit per stage
  localparam int SQ_LAST    = SQ_FIRST + ROOT_W - 1;
  localparam int ND_FIRST   = SQ_LAST + 1;   // normal quotients
  localparam int ND_LAST    = ND_FIRST + NQ_W - 1;
  localparam int S_OUT      = ND_LAST + 1;
  localparam int NST        = S_OUT + 1;

  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [PW-1:0] FMASK = PW'((65'd1 << FB) - 65'd1);

  typedef logic signed [CW-1:0] crd_t;

  // Everything a ray carries down the pipe
  typedef struct packed {
    crd_t [2:0]  o;
    crd_t [2:0]  d;
    crd_t [2:0]  e1;
    crd_t [2:0]  e2;
    crd_t [2:0]  s;
    crd_t [17:0] pr;
    crd_t [2:0]  h;
    crd_t [2:0]  q;
    crd_t [2:0]  n;
    crd_t [11:0] dp;
    crd_t        det;
    crd_t        nu;
    crd_t        nv;
    crd_t        nt;
    logic        hit;
    logic        tneg;
    logic        tsat;
    logic [CW-1:0] tun;
    logic [CW-2:0] tud;
    logic [CW-2:0] trem;
    logic [CW-1:0] tq;
    crd_t        t;
    crd_t [2:0]  tp;
    crd_t [2:0]  p;
    logic [2:0][CW-1:0]   nm;
    logic [2:0]           nneg;
    logic                 nz;
    logic [1:0]           nbi;
    logic [7:0]           nbyte;
    logic [MSB_W-1:0]     nmsb;
    logic [2:0][NS_W-1:0] ns;
    logic [2:0][SQ_W-1:0] nsq;
    logic [SUM_W-1:0]     srem;
    logic [ROOT_W-1:0]    sroot;
    logic [2:0][ROOT_W-1:0] ndrem;
    logic [2:0][NQ_W-1:0] nq;
    logic [2:0][NW-1:0]   unit;
  } rti_ctx_t;

  function automatic logic signed [PW-1:0] sx(input logic [CW-1:0] a);
    return {{(PW-CW){a[CW-1]}}, a};
  endfunction

  // Saturate a wide signed value into CW bits
  function automatic logic [CW-1:0] sat_w(input logic [PW-1:0] v);
    logic fits;
    fits = (v[PW-1:CW-1] == '0) || (v[PW-1:CW-1] == '1);
    if (fits) return v[CW-1:0];
    return v[PW-1] ? MINC : MAXC;
  endfunction

  // Fixed-point product, truncated toward zero, saturated
  function automatic logic [CW-1:0] mulq(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] r;
    p = sx(a) * sx(b);
    if (p[PW-1]) r = (p + FMASK) >>> FB;
    else         r = p >>> FB;
    return sat_w(r);
  endfunction

  function automatic logic [CW-1:0] abs_c(input logic [CW-1:0] a);
    return a[CW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic int nx3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int pv3(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

### rtl/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle test, signed Q16.16, fully pipelined.
// Depends on rtl/rti_pkg.sv (types, stage map, fixed-point helpers).
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in_      | in_valid/in_ready   | mode, vertex_sel, point_xyz, dir_xyz
//  out_     | out_valid/out_ready | hit, distance, hit_xyz, normal_xyz
//  cfg_     | APB, pready tied 1  | det_threshold at byte address 0
//
// One request per cycle while the output is not stalled. The normal path sets
// the pipeline depth: a 25-stage square root then 17-stage quotients.
// Vertex loads update the triangle on acceptance and produce no result.
// Reset (synchronous, rst_n low) empties the pipe, zeroes the triangle and sets
// det_threshold to 1. Each stage holds while the next is full and stalled.
module ray_triangle_intersect (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [1:0]               in_vertex_sel,
  input  logic signed [31:0]       in_point_x,
  input  logic signed [31:0]       in_point_y,
  input  logic signed [31:0]       in_point_z,
  input  logic signed [31:0]       in_dir_x,
  input  logic signed [31:0]       in_dir_y,
  input  logic signed [31:0]       in_dir_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [31:0]       out_distance,
  output logic signed [31:0]       out_hit_x,
  output logic signed [31:0]       out_hit_y,
  output logic signed [31:0]       out_hit_z,
  output logic signed [17:0]       out_normal_x,
  output logic signed [17:0]       out_normal_y,
  output logic signed [17:0]       out_normal_z,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int NST = rti_pkg::NST;
  localparam int CW  = rti_pkg::CW;

  logic [rti_pkg::THR_W-1:0] det_thr_r;
  logic [CW-1:0]             vtx_r [9];
  logic [NST-1:0]            v_r;
  logic [NST-1:0]            en;
  rti_pkg::rti_ctx_t         pipe_r  [NST];
  rti_pkg::rti_ctx_t         stg_nxt [NST];
  logic                      cfg_wr;
  logic                      load_acc;

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == rti_pkg::REG_DET_THR) ?
                      32'(det_thr_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r <= rti_pkg::THR_RESET;
    end else if (cfg_wr && cfg_paddr == rti_pkg::REG_DET_THR) begin
      det_thr_r <= cfg_pwdata[rti_pkg::THR_W-1:0];
    end
  end

  // Triangle store, written by load requests
  assign load_acc = in_valid && in_ready && (in_mode == rti_pkg::MODE_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) vtx_r[i] <= '0;
    end else if (load_acc) begin
      unique case (in_vertex_sel)
        rti_pkg::VSEL_A: begin
          vtx_r[0] <= in_point_x; vtx_r[1] <= in_point_y; vtx_r[2] <= in_point_z;
        end
        rti_pkg::VSEL_B: begin
          vtx_r[3] <= in_point_x; vtx_r[4] <= in_point_y; vtx_r[5] <= in_point_z;
        end
        rti_pkg::VSEL_C: begin
          vtx_r[6] <= in_point_x; vtx_r[7] <= in_point_y; vtx_r[8] <= in_point_z;
        end
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  // Entry stage: edges and origin offset from the current triangle
  always_comb begin
    logic [CW-1:0] o3 [3];
    stg_nxt[0] = '0;
    o3[0] = in_point_x; o3[1] = in_point_y; o3[2] = in_point_z;
    stg_nxt[0].d[0] = in_dir_x;
    stg_nxt[0].d[1] = in_dir_y;
    stg_nxt[0].d[2] = in_dir_z;
    for (int i = 0; i < 3; i++) begin
      stg_nxt[0].o[i]  = o3[i];
      stg_nxt[0].e1[i] = rti_pkg::sat_w(rti_pkg::sx(vtx_r[3+i]) - rti_pkg::sx(vtx_r[i]));
      stg_nxt[0].e2[i] = rti_pkg::sat_w(rti_pkg::sx(vtx_r[6+i]) - rti_pkg::sx(vtx_r[i]));
      stg_nxt[0].s[i]  = rti_pkg::sat_w(rti_pkg::sx(o3[i]) - rti_pkg::sx(vtx_r[i]));
    end
  end

  // Per-stage logic
  for (genvar k = 1; k < NST; k++) begin : g_stg
    localparam int TI = (k >= rti_pkg::TDIV_FIRST && k <= rti_pkg::TDIV_LAST) ?
                        rti_pkg::TDIV_LAST - k : 0;
    localparam int SB = (k >= rti_pkg::SQ_FIRST && k <= rti_pkg::SQ_LAST) ?
                        rti_pkg::SQ_LAST - k : 0;
    localparam int NI = (k >= rti_pkg::ND_FIRST && k <= rti_pkg::ND_LAST) ?
                        rti_pkg::ND_LAST - k : 0;

    always_comb begin
      rti_pkg::rti_ctx_t c;
      logic [CW-1:0]     tbits;
      logic [CW-1:0]     trem2;
      logic [51:0]       sq_sub;
      logic [rti_pkg::ROOT_W:0] nrem2;
      logic [CW:0]       nsum;
      logic              big;
      logic [CW-1:0]     w;
      c      = pipe_r[k-1];
      tbits  = '0;
      trem2  = '0;
      sq_sub = '0;
      nrem2  = '0;
      nsum   = '0;
      big    = 1'b0;
      w      = '0;

      // cross product terms: H = D x E2, Q = S x E1, N = E1 x E2
      if (k == rti_pkg::S_MUL1) begin
        for (int i = 0; i < 3; i++) begin
          c.pr[2*i]      = rti_pkg::mulq(c.d[rti_pkg::nx3(i)],  c.e2[rti_pkg::pv3(i)]);
          c.pr[2*i+1]    = rti_pkg::mulq(c.d[rti_pkg::pv3(i)],  c.e2[rti_pkg::nx3(i)]);
          c.pr[6+2*i]    = rti_pkg::mulq(c.s[rti_pkg::nx3(i)],  c.e1[rti_pkg::pv3(i)]);
          c.pr[6+2*i+1]  = rti_pkg::mulq(c.s[rti_pkg::pv3(i)],  c.e1[rti_pkg::nx3(i)]);
          c.pr[12+2*i]   = rti_pkg::mulq(c.e1[rti_pkg::nx3(i)], c.e2[rti_pkg::pv3(i)]);
          c.pr[12+2*i+1] = rti_pkg::mulq(c.e1[rti_pkg::pv3(i)], c.e2[rti_pkg::nx3(i)]);
        end
      end

      if (k == rti_pkg::S_CRS) begin
        for (int i = 0; i < 3; i++) begin
          c.h[i] = rti_pkg::sat_w(rti_pkg::sx(c.pr[2*i])    - rti_pkg::sx(c.pr[2*i+1]));
          c.q[i] = rti_pkg::sat_w(rti_pkg::sx(c.pr[6+2*i])  - rti_pkg::sx(c.pr[6+2*i+1]));
          c.n[i] = rti_pkg::sat_w(rti_pkg::sx(c.pr[12+2*i]) - rti_pkg::sx(c.pr[12+2*i+1]));
        end
      end

      // dot product terms; magnitudes of N
      if (k == rti_pkg::S_MUL2) begin
        for (int i = 0; i < 3; i++) begin
          c.dp[i]   = rti_pkg::mulq(c.h[i], c.e1[i]);
          c.dp[3+i] = rti_pkg::mulq(c.h[i], c.s[i]);
          c.dp[6+i] = rti_pkg::mulq(c.q[i], c.d[i]);
          c.dp[9+i] = rti_pkg::mulq(c.q[i], c.e2[i]);
          c.nm[i]   = rti_pkg::abs_c(c.n[i]);
          c.nneg[i] = c.n[i][CW-1];
        end
      end

      if (k == rti_pkg::S_DOT) begin
        c.det = rti_pkg::sat_w(rti_pkg::sx(c.dp[0]) + rti_pkg::sx(c.dp[1]) +
                               rti_pkg::sx(c.dp[2]));
        c.nu  = rti_pkg::sat_w(rti_pkg::sx(c.dp[3]) + rti_pkg::sx(c.dp[4]) +
                               rti_pkg::sx(c.dp[5]));
        c.nv  = rti_pkg::sat_w(rti_pkg::sx(c.dp[6]) + rti_pkg::sx(c.dp[7]) +
                               rti_pkg::sx(c.dp[8]));
        c.nt  = rti_pkg::sat_w(rti_pkg::sx(c.dp[9]) + rti_pkg::sx(c.dp[10]) +
                               rti_pkg::sx(c.dp[11]));
        // leading byte of the largest magnitude (MSB of the OR equals MSB of the max)
        w    = c.nm[0] | c.nm[1] | c.nm[2];
        c.nz = |w;
        if (w[31:24] != '0) begin
          c.nbi = 2'd3; c.nbyte = w[31:24];
        end else if (w[23:16] != '0) begin
          c.nbi = 2'd2; c.nbyte = w[23:16];
        end else if (w[15:8] != '0) begin
          c.nbi = 2'd1; c.nbyte = w[15:8];
        end else begin
          c.nbi = 2'd0; c.nbyte = w[7:0];
        end
      end

      // hit test, quotient setup, MSB position
      if (k == rti_pkg::S_HIT) begin
        nsum  = {c.nu[CW-1], c.nu} + {c.nv[CW-1], c.nv};
        c.hit = !c.det[CW-1] && (c.det != '0) &&
                (c.det >= CW'(det_thr_r)) &&
                !c.nu[CW-1] && ($signed(c.nu) <= $signed(c.det)) &&
                !c.nv[CW-1] && ($signed(nsum) <= $signed({c.det[CW-1], c.det}));
        c.tneg = c.nt[CW-1];
        c.tun  = rti_pkg::abs_c(c.nt);
        c.tud  = c.det[CW-2:0];
        c.tsat = ((CW-1)'(c.tun[CW-1:rti_pkg::FB]) >= c.tud);
        c.trem = (CW-1)'(c.tun[CW-1:rti_pkg::FB]);
        c.tq   = '0;
        c.nmsb = {c.nbi, 3'd0};
        for (int j = 0; j < 8; j++) begin
          if (c.nbyte[j]) c.nmsb = {c.nbi, 3'(j)};
        end
      end

      // t quotient, one bit per stage
      if (k >= rti_pkg::TDIV_FIRST && k <= rti_pkg::TDIV_LAST) begin
        tbits = {c.tun[rti_pkg::FB-1:0], {rti_pkg::FB{1'b0}}};
        trem2 = {c.trem, tbits[TI]};
        if (trem2 >= {1'b0, c.tud}) begin
          trem2    = trem2 - {1'b0, c.tud};
          c.tq[TI] = 1'b1;
        end
        c.trem = trem2[CW-2:0];
      end

      if (k == rti_pkg::S_TSAT) begin
        big = c.tsat || c.tq[CW-1];
        if (c.tneg) c.t = big ? rti_pkg::MINC : (~c.tq + 1'b1);
        else        c.t = big ? rti_pkg::MAXC : c.tq;
      end

      if (k == rti_pkg::S_PMUL) begin
        for (int i = 0; i < 3; i++) c.tp[i] = rti_pkg::mulq(c.t, c.d[i]);
      end

      if (k == rti_pkg::S_PADD) begin
        for (int i = 0; i < 3; i++)
          c.p[i] = rti_pkg::sat_w(rti_pkg::sx(c.o[i]) + rti_pkg::sx(c.tp[i]));
      end

      // scale |N| so the largest has its top bit at NS_W-1
      if (k == rti_pkg::S_NSHF) begin
        for (int i = 0; i < 3; i++) begin
          if (c.nmsb >= rti_pkg::MSB_W'(rti_pkg::NS_W - 1))
            c.ns[i] = rti_pkg::NS_W'(c.nm[i] >>
                      (c.nmsb - rti_pkg::MSB_W'(rti_pkg::NS_W - 1)));
          else
            c.ns[i] = rti_pkg::NS_W'(c.nm[i] <<
                      (rti_pkg::MSB_W'(rti_pkg::NS_W - 1) - c.nmsb));
        end
      end

      if (k == rti_pkg::S_NSQ) begin
        for (int i = 0; i < 3; i++) c.nsq[i] = c.ns[i] * c.ns[i];
      end

      if (k == rti_pkg::S_NSUM) begin
        c.srem  = rti_pkg::SUM_W'(c.nsq[0]) + rti_pkg::SUM_W'(c.nsq[1]) +
                  rti_pkg::SUM_W'(c.nsq[2]);
        c.sroot = '0;
      end

      // square root: try root bit SB, (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
      if (k >= rti_pkg::SQ_FIRST && k <= rti_pkg::SQ_LAST) begin
        sq_sub = (52'(c.sroot) << (SB + 1)) + (52'd1 << (2 * SB));
        if (52'(c.srem) >= sq_sub) begin
          c.srem      = c.srem - rti_pkg::SUM_W'(sq_sub);
          c.sroot[SB] = 1'b1;
        end
      end

      // normal quotients (m << FB) / len, bit NI
      if (k >= rti_pkg::ND_FIRST && k <= rti_pkg::ND_LAST) begin
        for (int i = 0; i < 3; i++) begin
          if (k == rti_pkg::ND_FIRST) nrem2 = (rti_pkg::ROOT_W + 1)'(c.ns[i]);
          else                        nrem2 = {c.ndrem[i], 1'b0};
          if (nrem2 >= {1'b0, c.sroot}) begin
            nrem2        = nrem2 - {1'b0, c.sroot};
            c.nq[i][NI]  = 1'b1;
          end else begin
            c.nq[i][NI]  = 1'b0;
          end
          c.ndrem[i] = nrem2[rti_pkg::ROOT_W-1:0];
        end
      end

      if (k == rti_pkg::S_OUT) begin
        for (int i = 0; i < 3; i++) begin
          if (!c.nz)         c.unit[i] = '0;
          else if (c.nneg[i]) c.unit[i] = ~{1'b0, c.nq[i]} + 1'b1;
          else               c.unit[i] = {1'b0, c.nq[i]};
        end
      end

      stg_nxt[k] = c;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) pipe_r[k] <= stg_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid && (in_mode == rti_pkg::MODE_RAY);
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Result: a miss reports all zeros
  assign out_valid    = v_r[NST-1];
  assign out_hit      = pipe_r[NST-1].hit;
  assign out_distance = out_hit ? pipe_r[NST-1].t    : '0;
  assign out_hit_x    = out_hit ? pipe_r[NST-1].p[0] : '0;
  assign out_hit_y    = out_hit ? pipe_r[NST-1].p[1] : '0;
  assign out_hit_z    = out_hit ? pipe_r[NST-1].p[2] : '0;
  assign out_normal_x = out_hit ? pipe_r[NST-1].unit[0] : '0;
  assign out_normal_y = out_hit ? pipe_r[NST-1].unit[1] : '0;
  assign out_normal_z = out_hit ? pipe_r[NST-1].unit[2] : '0;

  // Checks
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == rti_pkg::MODE_LOAD) |=> !v_r[0])
    else $error("load request entered the ray pipeline");

  a_hit_det_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!pipe_r[NST-1].det[CW-1] && pipe_r[NST-1].det != '0))
    else $error("hit reported with non-positive determinant");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_distance == '0 && out_hit_x == '0 &&
                                 out_normal_x == '0 && out_normal_z == '0))
    else $error("miss result carries nonzero fields");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_normal_y) <= 18'sd65536 &&
                   $signed(out_normal_y) >= -18'sd65536))
    else $error("normal component exceeds one");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
